/* hw/rtl/infix_to_postfix_converter_top_defines.svh */
// Assertion macros for the infix-to-postfix converter.
// Included by the top level; all macros compile to nothing under NO_ASSERTIONS.
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ITPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ITPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define ITPC_ASSERT(lbl, prop, msg)
`define ITPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/itpc_pkg.sv */
// Shared types, character codes and helper functions of the infix-to-postfix converter.
// No dependencies.
`timescale 1ns / 1ps

package itpc_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned SYM_W           = 8;

  localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;
  localparam logic [SYM_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;
  localparam logic [SYM_W-1:0] CH_POW   = 8'h5E;
  localparam logic [SYM_W-1:0] CH_UA    = 8'h41;
  localparam logic [SYM_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [SYM_W-1:0] CH_LA    = 8'h61;
  localparam logic [SYM_W-1:0] CH_LZ    = 8'h7A;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             ovf;
    logic             last;
  } res_t;

  function automatic logic is_letter(logic [SYM_W-1:0] c);
    return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
  endfunction

  // precedence; zero for anything that is not a binary operator
  function automatic logic [1:0] op_rank(logic [SYM_W-1:0] c);
    logic [1:0] r;
    case (c)
      CH_PLUS, CH_MINUS: r = 2'd1;
      CH_MUL, CH_DIV:    r = 2'd2;
      CH_POW:            r = 2'd3;
      default:           r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/infix_to_postfix_converter_top.sv */
// Infix-to-postfix converter top level: sequencer, stack RAM and output register.
// Depends on itpc_pkg, itpc_ram, itpc_seq, itpc_outreg and the defines header.
//
// Usage: one ASCII character enters per item on the input channel (in_valid_i,
// in_ready_o, symbol_i). Result items leave on the output channel (out_valid_o,
// out_ready_i) as out_symbol_o, overflow_o and last_o; last_o marks the final
// result caused by an input item. Items that cause no result give nothing.
// Letters pass straight through; operators and parentheses work on a stack of
// StackDepth entries kept in a synchronous RAM. Character 0 drains the stack
// and ends with a 0 terminator. A push onto a full stack yields one result
// with overflow_o set and the dropped character.
// A dropped character or a push that needs no look at the stack is done on acceptance;
// a letter, an overflowing '(' or a lone terminator is accepted, then handed off.
// An item that reads the stack top starts with the RAM read, pops one entry per step,
// settles the stop (push, discarded '(', overflow result or terminator) unless the
// stack ran empty under an operator or ')', and ends in a hand-off when it gave results.
// The next item is taken once the last result sits in the output register.
// Reset empties the stack and the output register. When the receiver stalls,
// results back up in the output register and the pending stage, and the
// sequencer holds until room frees up; nothing is lost.
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_top_defines.svh"

module infix_to_postfix_converter_top #(
  parameter int unsigned StackDepth = itpc_pkg::STACK_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [itpc_pkg::SYM_W-1:0] symbol_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [itpc_pkg::SYM_W-1:0] out_symbol_o,
  output logic                       overflow_o,
  output logic                       last_o
);

  localparam int unsigned CntW  = $clog2(StackDepth + 1);
  localparam int unsigned AddrW = $clog2(StackDepth);

  logic                       out_free;
  logic                       res_push;
  itpc_pkg::res_t             res;
  logic                       pend_vld;
  logic [CntW-1:0]            count;
  logic                       ram_we, ram_re;
  logic [AddrW-1:0]           ram_waddr, ram_raddr;
  logic [itpc_pkg::SYM_W-1:0] ram_wdata, ram_rdata;

  itpc_seq #(
    .StackDepth(StackDepth)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .symbol_i   (symbol_i),
    .out_free_i (out_free),
    .res_valid_o(res_push),
    .res_o      (res),
    .pend_vld_o (pend_vld),
    .count_o    (count),
    .we_o       (ram_we),
    .waddr_o    (ram_waddr),
    .wdata_o    (ram_wdata),
    .re_o       (ram_re),
    .raddr_o    (ram_raddr),
    .rdata_i    (ram_rdata)
  );

  itpc_ram #(
    .Width(itpc_pkg::SYM_W),
    .Depth(StackDepth)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  itpc_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_symbol_o(out_symbol_o),
    .overflow_o  (overflow_o),
    .last_o      (last_o)
  );

  `ITPC_ASSERT(a_push_has_room, res_push |-> out_free, "result pushed into a full output register")
  `ITPC_ASSERT(a_count_range, count <= CntW'(StackDepth), "stack count beyond depth")
  `ITPC_ASSERT(a_ready_no_pend, in_ready_o |-> !pend_vld, "input ready with a result pending")
  `ITPC_ASSERT_NEXT(a_last_frees_in, res_push && res.last, in_ready_o, "not ready after last result")

endmodule

/* hw/rtl/itpc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module itpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/itpc_seq.sv */
// Sequencer: decodes symbols, runs the operator stack held in itpc_ram and
// produces result items with a one-deep pending stage to place the last flag. Uses itpc_pkg.
`timescale 1ns / 1ps

module itpc_seq #(
  parameter int unsigned StackDepth = itpc_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [itpc_pkg::SYM_W-1:0]          symbol_i,
  input  logic                                out_free_i,
  output logic                                res_valid_o,
  output itpc_pkg::res_t                      res_o,
  output logic                                pend_vld_o,
  output logic [$clog2(StackDepth+1)-1:0]     count_o,
  output logic                                we_o,
  output logic [$clog2(StackDepth)-1:0]       waddr_o,
  output logic [itpc_pkg::SYM_W-1:0]          wdata_o,
  output logic                                re_o,
  output logic [$clog2(StackDepth)-1:0]       raddr_o,
  input  logic [itpc_pkg::SYM_W-1:0]          rdata_i
);

  localparam int unsigned CntW  = $clog2(StackDepth + 1);
  localparam int unsigned AddrW = $clog2(StackDepth);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_TERM  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [itpc_pkg::SYM_W-1:0]   sym_q, sym_d;
  logic                         pend_vld_q, pend_vld_d;
  logic [itpc_pkg::SYM_W-1:0]   pend_sym_q, pend_sym_d;
  logic                         pend_ovf_q, pend_ovf_d;

  logic [CntW-1:0]              cnt_m1, cnt_m2;
  logic                         full, can_emit, want_emit, emit_ovf;
  logic [itpc_pkg::SYM_W-1:0]   emit_sym;
  logic                         pop_more;

  assign cnt_m1   = cnt_q - CntW'(1);
  assign cnt_m2   = cnt_q - CntW'(2);
  assign full     = (cnt_q == CntW'(StackDepth));
  assign can_emit = !pend_vld_q || out_free_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign pend_vld_o = pend_vld_q;
  assign count_o    = cnt_q;

  // pop continues while the stack top is an operator to emit
  always_comb begin
    if (sym_q == itpc_pkg::CH_NUL) begin
      pop_more = 1'b1;
    end else if (sym_q == itpc_pkg::CH_RPAR) begin
      pop_more = (rdata_i != itpc_pkg::CH_LPAR);
    end else begin
      pop_more = (itpc_pkg::op_rank(rdata_i) >= itpc_pkg::op_rank(sym_q));
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    sym_d      = sym_q;
    pend_vld_d = pend_vld_q;
    pend_sym_d = pend_sym_q;
    pend_ovf_d = pend_ovf_q;
    we_o       = 1'b0;
    waddr_o    = cnt_q[AddrW-1:0];
    wdata_o    = sym_q;
    re_o       = 1'b0;
    raddr_o    = cnt_m1[AddrW-1:0];
    want_emit  = 1'b0;
    emit_sym   = '0;
    emit_ovf   = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sym_d   = symbol_i;
          wdata_o = symbol_i;
          if (itpc_pkg::is_letter(symbol_i)) begin
            want_emit = 1'b1;
            emit_sym  = symbol_i;
            state_d   = S_FLUSH;
          end else if (symbol_i == itpc_pkg::CH_LPAR) begin
            if (!full) begin
              we_o  = 1'b1;
              cnt_d = cnt_q + CntW'(1);
            end else begin
              want_emit = 1'b1;
              emit_sym  = symbol_i;
              emit_ovf  = 1'b1;
              state_d   = S_FLUSH;
            end
          end else if ((symbol_i == itpc_pkg::CH_RPAR) || (symbol_i == itpc_pkg::CH_NUL) ||
                       (itpc_pkg::op_rank(symbol_i) != 2'd0)) begin
            if (cnt_q != '0) begin
              re_o    = 1'b1;
              state_d = S_EVAL;
            end else if (symbol_i == itpc_pkg::CH_NUL) begin
              want_emit = 1'b1;
              emit_sym  = itpc_pkg::CH_NUL;
              state_d   = S_FLUSH;
            end else if (symbol_i != itpc_pkg::CH_RPAR) begin
              we_o  = 1'b1;
              cnt_d = cnt_q + CntW'(1);
            end
          end
        end
      end

      S_EVAL: begin
        if (pop_more) begin
          want_emit = 1'b1;
          emit_sym  = rdata_i;
          if (can_emit) begin
            cnt_d = cnt_m1;
            if (cnt_m1 != '0) begin
              re_o    = 1'b1;
              raddr_o = cnt_m2[AddrW-1:0];
            end else if (sym_q == itpc_pkg::CH_NUL) begin
              state_d = S_TERM;
            end else if (sym_q == itpc_pkg::CH_RPAR) begin
              state_d = S_FLUSH;
            end else begin
              // pop of the last entry and push of the new operator share slot zero
              we_o    = 1'b1;
              waddr_o = cnt_m1[AddrW-1:0];
              cnt_d   = cnt_q;
              state_d = S_FLUSH;
            end
          end
        end else if (sym_q == itpc_pkg::CH_RPAR) begin
          cnt_d   = cnt_m1;
          state_d = pend_vld_q ? S_FLUSH : S_IDLE;
        end else if (!full) begin
          we_o    = 1'b1;
          cnt_d   = cnt_q + CntW'(1);
          state_d = pend_vld_q ? S_FLUSH : S_IDLE;
        end else begin
          want_emit = 1'b1;
          emit_sym  = sym_q;
          emit_ovf  = 1'b1;
          if (can_emit) begin
            state_d = S_FLUSH;
          end
        end
      end

      S_TERM: begin
        want_emit = 1'b1;
        emit_sym  = itpc_pkg::CH_NUL;
        if (can_emit) begin
          state_d = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          res_o       = '{sym: pend_sym_q, ovf: pend_ovf_q, last: 1'b1};
          pend_vld_d  = 1'b0;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a new result pushes the pending one out, which then cannot be the last
    if (want_emit && can_emit) begin
      if (pend_vld_q) begin
        res_valid_o = 1'b1;
        res_o       = '{sym: pend_sym_q, ovf: pend_ovf_q, last: 1'b0};
      end
      pend_vld_d = 1'b1;
      pend_sym_d = emit_sym;
      pend_ovf_d = emit_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    pend_sym_q <= pend_sym_d;
    pend_ovf_q <= pend_ovf_d;
  end

endmodule

/* hw/rtl/itpc_outreg.sv */
// Output register of the converter: holds one result item until the receiver takes it.
// Uses itpc_pkg.
`timescale 1ns / 1ps

module itpc_outreg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  itpc_pkg::res_t             res_i,
  output logic                       free_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [itpc_pkg::SYM_W-1:0] out_symbol_o,
  output logic                       overflow_o,
  output logic                       last_o
);

  logic           vld_q, vld_d;
  itpc_pkg::res_t res_q;

  assign free_o = !vld_q || out_ready_i;
  assign vld_d  = push_i || (vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o  = vld_q;
  assign out_symbol_o = res_q.sym;
  assign overflow_o   = res_q.ovf;
  assign last_o       = res_q.last;

endmodule

/* bench/tb_infix_to_postfix_converter_top.sv */
// Self-checking testbench for infix_to_postfix_converter_top: directed and random
// expressions go in, postfix results are predicted and checked item by item.
// Depends on itpc_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter_top;

  localparam int unsigned DEPTH        = itpc_pkg::STACK_DEPTH_DEF;
  localparam int unsigned SYM_W        = itpc_pkg::SYM_W;
  localparam int          DRAIN_CYCLES = 2 * DEPTH + 16;
  localparam int          HOLD_CYCLES  = 300;

  typedef itpc_pkg::res_t res_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [SYM_W-1:0]  symbol_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [SYM_W-1:0]  out_symbol_o;
  logic              overflow_o;
  logic              last_o;

  infix_to_postfix_converter_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .symbol_i    (symbol_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_symbol_o(out_symbol_o),
    .overflow_o  (overflow_o),
    .last_o      (last_o)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [SYM_W-1:0] opstk [DEPTH];
  int unsigned      opstk_cnt = 0;
  res_t             postfix_q [$];

  int err_cnt = 0;
  int n_items = 0;
  int n_ignored = 0;
  int n_results = 0;
  int n_ovf = 0;
  int max_depth = 0;

  int tx_burst_left = 0;
  bit tx_idle_en = 1'b1;
  bit hold_tog = 1'b0;

  logic [SYM_W-1:0] op_set [5] = '{itpc_pkg::CH_PLUS, itpc_pkg::CH_MINUS, itpc_pkg::CH_MUL,
                                   itpc_pkg::CH_DIV, itpc_pkg::CH_POW};

  function automatic int prec_of(logic [SYM_W-1:0] c);
    if (c == itpc_pkg::CH_PLUS || c == itpc_pkg::CH_MINUS) return 1;
    if (c == itpc_pkg::CH_MUL || c == itpc_pkg::CH_DIV) return 2;
    if (c == itpc_pkg::CH_POW) return 3;
    return 0;
  endfunction

  function automatic bit is_alpha(logic [SYM_W-1:0] c);
    return (c >= itpc_pkg::CH_UA && c <= itpc_pkg::CH_UZ) ||
           (c >= itpc_pkg::CH_LA && c <= itpc_pkg::CH_LZ);
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic stack_push(input logic [SYM_W-1:0] c, ref res_t rq[$]);
    if (opstk_cnt < DEPTH) begin
      opstk[opstk_cnt] = c;
      opstk_cnt++;
      if (opstk_cnt > max_depth) max_depth = opstk_cnt;
    end else begin
      rq.push_back('{sym: c, ovf: 1'b1, last: 1'b0});
      n_ovf++;
    end
  endtask

  task automatic predict_postfix(input logic [SYM_W-1:0] c);
    res_t rq [$];
    int   rank;
    rank = prec_of(c);
    if (is_alpha(c)) begin
      rq.push_back('{sym: c, ovf: 1'b0, last: 1'b0});
    end else if (c == itpc_pkg::CH_LPAR) begin
      stack_push(c, rq);
    end else if (c == itpc_pkg::CH_RPAR) begin
      while (opstk_cnt > 0 && opstk[opstk_cnt-1] != itpc_pkg::CH_LPAR) begin
        opstk_cnt--;
        rq.push_back('{sym: opstk[opstk_cnt], ovf: 1'b0, last: 1'b0});
      end
      if (opstk_cnt > 0) opstk_cnt--;
    end else if (rank > 0) begin
      while (opstk_cnt > 0 && prec_of(opstk[opstk_cnt-1]) >= rank) begin
        opstk_cnt--;
        rq.push_back('{sym: opstk[opstk_cnt], ovf: 1'b0, last: 1'b0});
      end
      stack_push(c, rq);
    end else if (c == itpc_pkg::CH_NUL) begin
      while (opstk_cnt > 0) begin
        opstk_cnt--;
        rq.push_back('{sym: opstk[opstk_cnt], ovf: 1'b0, last: 1'b0});
      end
      rq.push_back('{sym: itpc_pkg::CH_NUL, ovf: 1'b0, last: 1'b0});
    end
    if (rq.size() == 0) n_ignored++;
    else rq[rq.size()-1].last = 1'b1;
    foreach (rq[i]) postfix_q.push_back(rq[i]);
  endtask

  // sender: bursts with random gaps; valid is held until the item is taken
  task automatic send_sym(input logic [SYM_W-1:0] c);
    if (tx_idle_en && tx_burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      tx_burst_left = $urandom_range(1, 10);
    end
    if (tx_burst_left > 0) tx_burst_left--;
    in_valid_i <= 1'b1;
    symbol_i   <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_items++;
    predict_postfix(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_sym(s[i]);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (postfix_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [SYM_W-1:0] rand_letter();
    return $urandom_range(0, 1) ? SYM_W'($urandom_range(itpc_pkg::CH_UA, itpc_pkg::CH_UZ))
                                : SYM_W'($urandom_range(itpc_pkg::CH_LA, itpc_pkg::CH_LZ));
  endfunction

  function automatic logic [SYM_W-1:0] rand_noise();
    logic [SYM_W-1:0] c;
    do c = SYM_W'($urandom_range(1, 255));
    while (is_alpha(c) || prec_of(c) > 0 || c == itpc_pkg::CH_LPAR ||
           c == itpc_pkg::CH_RPAR);
    return c;
  endfunction

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk_i) begin
    static bit          hold_seen = 1'b0;
    static int          hold_left = 0;
    static int          mode_left = 0;
    static int unsigned rx_mode   = 0;
    static int unsigned rx_phase  = 0;
    rx_phase++;
    if (hold_tog != hold_seen) begin
      hold_seen = hold_tog;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        2: out_ready_i <= (rx_phase % 5) < 2;
        default: out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (postfix_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result sym=%02h ovf=%b last=%b",
                                  out_symbol_o, overflow_o, last_o));
      end else begin
        exp_r = postfix_q.pop_front();
        if (out_symbol_o !== exp_r.sym || overflow_o !== exp_r.ovf || last_o !== exp_r.last)
          report_mismatch($sformatf("got sym=%02h ovf=%b last=%b, exp sym=%02h ovf=%b last=%b",
                                    out_symbol_o, overflow_o, last_o,
                                    exp_r.sym, exp_r.ovf, exp_r.last));
      end
    end
  end

  task automatic test_precedence();
    send_text("A+z*Z^a^b-c/d");
    send_sym(itpc_pkg::CH_NUL);
    wait_drained();
  endtask

  task automatic test_parens_and_noise();
    send_text("(a+");
    send_sym(8'hFF);
    send_text("b)*@[`{ 9c");
    send_sym(8'h80);
    send_sym(itpc_pkg::CH_NUL);
    wait_drained();
  endtask

  task automatic test_unmatched_and_empty();
    send_text("a-b)((");
    send_sym(itpc_pkg::CH_NUL);
    send_sym(itpc_pkg::CH_NUL);
    wait_drained();
  endtask

  task automatic test_stack_overflow();
    tx_idle_en = 1'b0;
    repeat (DEPTH) send_sym(itpc_pkg::CH_LPAR);
    send_sym(itpc_pkg::CH_LPAR);
    send_sym(itpc_pkg::CH_POW);
    send_sym(itpc_pkg::CH_RPAR);
    send_sym(itpc_pkg::CH_MUL);
    send_sym(itpc_pkg::CH_NUL);
    tx_idle_en = 1'b1;
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    hold_tog <= ~hold_tog;
    send_sym(rand_letter());
    repeat (20) begin
      send_sym(op_set[$urandom_range(0, 4)]);
      send_sym(rand_letter());
    end
    send_sym(itpc_pkg::CH_NUL);
    tx_idle_en = 1'b1;
    wait_drained();
  endtask

  task automatic send_random_expression();
    int unsigned kind;
    int          n_opnd;
    int          depth;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) send_sym(SYM_W'($urandom_range(0, 255)));
      send_sym(itpc_pkg::CH_NUL);
      return;
    end
    n_opnd = $urandom_range(1, 12);
    depth  = 0;
    while (n_opnd > 0) begin
      if ($urandom_range(0, 9) == 0) send_sym(rand_noise());
      if (depth < 10 && $urandom_range(0, 3) == 0) begin
        send_sym(itpc_pkg::CH_LPAR);
        depth++;
      end else begin
        send_sym(rand_letter());
        n_opnd--;
        while (depth > 0 && $urandom_range(0, 2) == 0) begin
          send_sym(itpc_pkg::CH_RPAR);
          depth--;
        end
        if (n_opnd > 0) send_sym(op_set[$urandom_range(0, 4)]);
      end
    end
    if (kind == 1) begin
      if ($urandom_range(0, 1)) send_sym(itpc_pkg::CH_RPAR);
    end else begin
      while (depth > 0) begin
        send_sym(itpc_pkg::CH_RPAR);
        depth--;
      end
    end
    send_sym(itpc_pkg::CH_NUL);
  endtask

  task automatic test_random_expressions();
    int target;
    target = (n_items - n_ignored) + 40;
    while ((n_items - n_ignored) < target) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      send_random_expression();
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    tx_idle_en = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_precedence();
    test_parens_and_noise();
    test_unmatched_and_empty();
    test_stack_overflow();
    test_backpressure();
    test_random_expressions();
    if (postfix_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", postfix_q.size()));
    $display("Summary: %0d items sent (%0d gave no result), %0d results checked",
             n_items, n_ignored, n_results);
    $display("Summary: %0d overflow results, deepest stack %0d, %0d mismatches",
             n_ovf, max_depth, err_cnt);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout waiting for the converter");
    $display("TEST FAILED");
    $finish;
  end

endmodule
